### rtl/local_alignment_score_fill_macros.svh
// Assertion macros used by local_alignment_score_fill.sv.
`ifndef LOCAL_ALIGNMENT_SCORE_FILL_MACROS_SVH
`define LOCAL_ALIGNMENT_SCORE_FILL_MACROS_SVH

// Checked at every clock edge outside reset.
`define LASF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LASF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/lasf_pkg.sv
package lasf_pkg;

  localparam int DEF_MAX_TEMPLATE = 64;
  localparam int DEF_SCORE_BITS   = 16;

  localparam int BASE_W  = 8;
  localparam int COEF_W  = 8;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 16;
  localparam int THR_W   = 16;
  localparam int TIDX_W  = 6;
  localparam int ACT_W   = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEQ     = 2'd2;

  localparam logic [CIDX_W-1:0] REG_MATCH     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MISMATCH  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GAP       = 3'd2;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LENGTH    = 3'd4;

  localparam logic [COL_W-1:0] COL_MAX = '1;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### rtl/local_alignment_score_fill.sv
// A sequence base moves the block to its run state on acceptance; row 1 reaches the output
// register on the first run step. The run then rotates the full cell ring once, one row
// result per cycle while the output is not stalled, and the input stalls until it ends;
// loads and restarts are taken in idle and start no run.
// Reset: async, active low; scores, column counter and control clear, registers take defaults.
// Template bases are undefined until loaded.
`include "local_alignment_score_fill_macros.svh"

module local_alignment_score_fill
  import lasf_pkg::*;
#(
  parameter int MAX_TEMPLATE = DEF_MAX_TEMPLATE,
  parameter int SCORE_BITS   = DEF_SCORE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CIDX_W-1:0]     cfg_index_i,
  input  logic [CDATA_W-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      in_action_i,
  input  logic [BASE_W-1:0]     in_base_i,
  input  logic [TIDX_W-1:0]     in_template_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_column_o,
  output logic [SCORE_BITS-1:0] out_score_o,
  output logic [2:0]            out_trace_o,
  output logic                  out_hit_o,
  output logic                  out_last_o
);

  localparam int IW = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
  localparam int HW = (SCORE_BITS > THR_W) ? SCORE_BITS : THR_W;
  localparam logic [IW-1:0]    K_LAST  = IW'(MAX_TEMPLATE - 1);
  localparam logic [ROW_W-1:0] LEN_MAX = ROW_W'(MAX_TEMPLATE);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                   state_q;
  logic [IW-1:0]            k_q;
  logic [SCORE_BITS-1:0]    above_new_q, above_old_q;
  logic [BASE_W-1:0]        seq_base_q;
  logic [COL_W-1:0]         col_q;
  logic signed [COEF_W-1:0] match_q, mismatch_q, gap_q;
  logic [THR_W-1:0]         thr_q;
  logic [ROW_W-1:0]         tlen_q;

  logic                     out_valid_q, out_hit_q, out_last_q;
  logic [ROW_W-1:0]         out_row_q;
  logic [COL_W-1:0]         out_col_q;
  logic [SCORE_BITS-1:0]    out_score_q;
  logic [2:0]               out_trace_q;

  logic [BASE_W-1:0]     cell_base [MAX_TEMPLATE];
  logic [SCORE_BITS-1:0] cell_score [MAX_TEMPLATE];
  logic [BASE_W-1:0]     head_base_d;
  logic [SCORE_BITS-1:0] head_score_d;

  logic [ROW_W-1:0]      len;
  logic [ROW_W-1:0]      row;
  logic                  in_acc, cfg_acc, out_free, active, step;
  logic                  do_load, do_clear;
  logic [SCORE_BITS-1:0] pe_score;
  logic [2:0]            pe_trace;

  always_comb begin
    if (tlen_q == '0) begin
      len = ROW_W'(1);
    end else if (tlen_q > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = tlen_q;
    end
  end

  assign in_stall_o  = (state_q == ST_RUN);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign row         = ROW_W'(k_q) + ROW_W'(1);
  assign active      = (ROW_W'(k_q) < len);
  assign step        = (state_q == ST_RUN) && (!active || out_free);
  assign do_clear    = in_acc && (in_action_i == ACT_RESTART);
  assign do_load     = in_acc && (in_action_i == ACT_LOAD) &&
                       ({1'b0, in_template_index_i} < (TIDX_W + 1)'(MAX_TEMPLATE));

  lasf_pe #(
    .SCORE_BITS(SCORE_BITS)
  ) u_pe (
    .same_i     (cell_base[0] == seq_base_q),
    .above_new_i(above_new_q),
    .above_old_i(above_old_q),
    .left_i     (cell_score[0]),
    .match_i    (match_q),
    .mismatch_i (mismatch_q),
    .gap_i      (gap_q),
    .score_o    (pe_score),
    .trace_o    (pe_trace)
  );

  assign head_base_d  = cell_base[0];
  assign head_score_d = active ? pe_score : cell_score[0];

  for (genvar i = 0; i < MAX_TEMPLATE; i++) begin : g_cell
    cell_ctrl_t            ctrl;
    logic [BASE_W-1:0]     nb;
    logic [SCORE_BITS-1:0] ns;

    assign ctrl.clear = do_clear;
    assign ctrl.shift = step;
    assign ctrl.load  = do_load && (in_template_index_i[IW-1:0] == IW'(i));

    if (i == MAX_TEMPLATE - 1) begin : g_tail
      assign nb = head_base_d;
      assign ns = head_score_d;
    end else begin : g_mid
      assign nb = cell_base[i+1];
      assign ns = cell_score[i+1];
    end

    lasf_cell #(
      .SCORE_BITS(SCORE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_base_i(in_base_i),
      .base_i     (nb),
      .score_i    (ns),
      .base_o     (cell_base[i]),
      .score_o    (cell_score[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      col_q       <= '0;
      seq_base_q  <= '0;
      above_new_q <= '0;
      above_old_q <= '0;
      match_q     <= 8'sd1;
      mismatch_q  <= -8'sd1;
      gap_q       <= -8'sd2;
      thr_q       <= THR_W'(10);
      tlen_q      <= ROW_W'(64);
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_score_q <= '0;
      out_trace_q <= '0;
      out_hit_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_MATCH:     match_q    <= cfg_data_i[COEF_W-1:0];
          REG_MISMATCH:  mismatch_q <= cfg_data_i[COEF_W-1:0];
          REG_GAP:       gap_q      <= cfg_data_i[COEF_W-1:0];
          REG_THRESHOLD: thr_q      <= cfg_data_i[THR_W-1:0];
          REG_LENGTH:    tlen_q     <= cfg_data_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && !(step && active)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (do_clear) begin
            col_q <= '0;
          end else if (in_acc && in_action_i == ACT_SEQ) begin
            state_q     <= ST_RUN;
            k_q         <= '0;
            seq_base_q  <= in_base_i;
            above_new_q <= '0;
            above_old_q <= '0;
            if (col_q != COL_MAX) begin
              col_q <= col_q + COL_W'(1);
            end
          end
        end
        ST_RUN: begin
          if (step) begin
            if (active) begin
              above_old_q <= cell_score[0];
              above_new_q <= pe_score;
              out_valid_q <= 1'b1;
              out_row_q   <= row;
              out_col_q   <= col_q;
              out_score_q <= pe_score;
              out_trace_q <= pe_trace;
              out_hit_q   <= (HW'(pe_score) >= HW'(thr_q));
              out_last_q  <= (row == len);
            end
            if (k_q == K_LAST) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q + IW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_column_o = out_col_q;
  assign out_score_o  = out_score_q;
  assign out_trace_o  = out_trace_q;
  assign out_hit_o    = out_hit_q;
  assign out_last_o   = out_last_q;

  `LASF_ASSERT(a_run_ends, step && k_q == K_LAST |=> state_q == ST_IDLE, "run overran")
  `LASF_ASSERT(a_last_row, out_valid_o && out_last_o |-> out_row_o == len, "bad last")
  `LASF_ASSERT(a_row_range, out_valid_o |-> out_row_o != '0 && out_row_o <= len, "bad row")
  `LASF_ASSERT(a_trace_zero, out_valid_o && out_trace_o == '0 |-> out_score_o == '0, "bad trace")
  `LASF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> state_q == ST_IDLE && !out_valid_o, "busy in reset")

endmodule

### rtl/lasf_cell.sv
module lasf_cell
  import lasf_pkg::*;
#(
  parameter int SCORE_BITS = DEF_SCORE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [BASE_W-1:0]     load_base_i,
  input  logic [BASE_W-1:0]     base_i,
  input  logic [SCORE_BITS-1:0] score_i,
  output logic [BASE_W-1:0]     base_o,
  output logic [SCORE_BITS-1:0] score_o
);

  logic [BASE_W-1:0]     base_q;
  logic [SCORE_BITS-1:0] score_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      base_q <= base_i;
    end else if (ctrl_i.load) begin
      base_q <= load_base_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
    end else if (ctrl_i.clear) begin
      score_q <= '0;
    end else if (ctrl_i.shift) begin
      score_q <= score_i;
    end
  end

  assign base_o  = base_q;
  assign score_o = score_q;

endmodule

### rtl/lasf_pe.sv
module lasf_pe
  import lasf_pkg::*;
#(
  parameter int SCORE_BITS = DEF_SCORE_BITS
) (
  input  logic                     same_i,
  input  logic [SCORE_BITS-1:0]    above_new_i,
  input  logic [SCORE_BITS-1:0]    above_old_i,
  input  logic [SCORE_BITS-1:0]    left_i,
  input  logic signed [COEF_W-1:0] match_i,
  input  logic signed [COEF_W-1:0] mismatch_i,
  input  logic signed [COEF_W-1:0] gap_i,
  output logic [SCORE_BITS-1:0]    score_o,
  output logic [2:0]               trace_o
);

  localparam int CW = SCORE_BITS + 2;

  logic signed [CW-1:0] gap_x, diag_x, vert, diag, horz, best;

  always_comb begin
    gap_x  = {{(CW-COEF_W){gap_i[COEF_W-1]}}, gap_i};
    diag_x = same_i ? {{(CW-COEF_W){match_i[COEF_W-1]}}, match_i}
                    : {{(CW-COEF_W){mismatch_i[COEF_W-1]}}, mismatch_i};
    vert = signed'({2'b00, above_new_i}) + gap_x;
    diag = signed'({2'b00, above_old_i}) + diag_x;
    horz = signed'({2'b00, left_i}) + gap_x;
    best = '0;
    if (vert > best) best = vert;
    if (diag > best) best = diag;
    if (horz > best) best = horz;
    trace_o = {horz == best, diag == best, vert == best};
    score_o = (best[CW-1:SCORE_BITS] != 2'b00) ? {SCORE_BITS{1'b1}}
                                               : best[SCORE_BITS-1:0];
  end

endmodule

### dv/local_alignment_score_fill_test.sv
module local_alignment_score_fill_test;
  import lasf_pkg::*;

  localparam int MAX_T      = DEF_MAX_TEMPLATE;
  localparam int SCORE_BITS = DEF_SCORE_BITS;
  localparam int SCORE_TOP  = (1 << SCORE_BITS) - 1;
  localparam int SETTLE     = MAX_T + 16;

  localparam logic [ACT_W-1:0]  ACT_NONE  = 2'd3;
  localparam logic [CIDX_W-1:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic [SCORE_BITS-1:0] score;
    logic [2:0]            trace;
    logic                  hit;
    logic                  last;
  } cell_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CIDX_W-1:0]     cfg_index_i;
  logic [CDATA_W-1:0]    cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ACT_W-1:0]      in_action_i;
  logic [BASE_W-1:0]     in_base_i;
  logic [TIDX_W-1:0]     in_template_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ROW_W-1:0]      out_row_o;
  logic [COL_W-1:0]      out_column_o;
  logic [SCORE_BITS-1:0] out_score_o;
  logic [2:0]            out_trace_o;
  logic                  out_hit_o;
  logic                  out_last_o;

  // scoring state mirrored from the register writes and accepted requests
  int          coef_match    = 1;
  int          coef_mismatch = -1;
  int          coef_gap      = -2;
  int          hit_level     = 10;
  logic [6:0]  tmpl_len      = 7'd64;
  logic [7:0]  tmpl_base [MAX_T];
  int          col_scores [MAX_T];
  int          col_count     = 0;

  cell_t       cells_due [$];
  int          errors        = 0;
  bit          quiet         = 1'b0;
  int          stall_left    = 0;

  local_alignment_score_fill #(
    .MAX_TEMPLATE(MAX_T),
    .SCORE_BITS  (SCORE_BITS)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .in_action_i,
    .in_base_i,
    .in_template_index_i,
    .out_valid_o,
    .out_stall_i,
    .out_row_o,
    .out_column_o,
    .out_score_o,
    .out_trace_o,
    .out_hit_o,
    .out_last_o
  );

  always #2 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task automatic check_field(string name, cell_t want, logic [31:0] got,
                             logic [31:0] exp_val);
    if (got !== exp_val)
      report($sformatf("%s got %0d want %0d at row %0d column %0d",
                       name, got, exp_val, want.row, want.column));
  endtask

  function automatic void fill_column(logic [7:0] base);
    int    len, above_new, above_old, left, vert, horz, diag, best, sat;
    cell_t c;
    if (col_count < 65535) col_count++;
    len = int'(tmpl_len);
    if (len < 1) len = 1;
    if (len > MAX_T) len = MAX_T;
    above_new = 0;
    above_old = 0;
    for (int r = 0; r < len; r++) begin
      left = col_scores[r];
      vert = above_new + coef_gap;
      horz = left + coef_gap;
      diag = above_old + ((tmpl_base[r] == base) ? coef_match : coef_mismatch);
      best = 0;
      if (vert > best) best = vert;
      if (diag > best) best = diag;
      if (horz > best) best = horz;
      sat = (best > SCORE_TOP) ? SCORE_TOP : best;
      c.row    = ROW_W'(r + 1);
      c.column = COL_W'(col_count);
      c.score  = SCORE_BITS'(sat);
      c.trace  = {horz == best, diag == best, vert == best};
      c.hit    = (sat >= hit_level);
      c.last   = (r + 1 == len);
      cells_due.insert(cells_due.size(), c);
      above_old     = left;
      above_new     = sat;
      col_scores[r] = sat;
    end
  endfunction

  function automatic void apply_request(logic [ACT_W-1:0] action, logic [7:0] base,
                                        logic [5:0] idx);
    case (action)
      ACT_LOAD: begin
        tmpl_base[idx] = base;
      end
      ACT_RESTART: begin
        foreach (col_scores[i]) col_scores[i] = 0;
        col_count = 0;
      end
      ACT_SEQ: begin
        fill_column(base);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 4))
      0: return 8'h41;
      1: return 8'h43;
      2: return 8'h47;
      3: return 8'h54;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  always @(posedge clk_i) begin : check_cells
    cell_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cells_due.size() == 0) begin
        report($sformatf("unexpected result row %0d column %0d", out_row_o, out_column_o));
      end else begin
        want = cells_due.pop_front();
        check_field("row",    want, 32'(out_row_o),    32'(want.row));
        check_field("column", want, 32'(out_column_o), 32'(want.column));
        check_field("score",  want, 32'(out_score_o),  32'(want.score));
        check_field("trace",  want, 32'(out_trace_o),  32'(want.trace));
        check_field("hit",    want, 32'(out_hit_o),    32'(want.hit));
        check_field("last",   want, 32'(out_last_o),   32'(want.last));
      end
    end
  end

  task automatic send_request(logic [ACT_W-1:0] action, logic [7:0] base, logic [5:0] idx);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    in_action_i         <= action;
    in_base_i           <= base;
    in_template_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(action, base, idx);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MATCH:     coef_match    = $signed(data[7:0]);
      REG_MISMATCH:  coef_mismatch = $signed(data[7:0]);
      REG_GAP:       coef_gap      = $signed(data[7:0]);
      REG_THRESHOLD: hit_level     = int'(data);
      REG_LENGTH:    tmpl_len      = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // upper data bits are junk on purpose for the narrow registers
  task automatic set_scoring(int m, int mm, int g, int thr, int len);
    wait_drained();
    cfg_write(REG_MATCH,     {8'($urandom), 8'(m)});
    cfg_write(REG_MISMATCH,  {8'($urandom), 8'(mm)});
    cfg_write(REG_GAP,       {8'($urandom), 8'(g)});
    cfg_write(REG_THRESHOLD, 16'(thr));
    cfg_write(REG_LENGTH,    {9'($urandom), 7'(len)});
  endtask

  task automatic test_defaults();
    for (int i = 0; i < MAX_T; i++) send_request(ACT_LOAD, pick_base(), 6'(i));
    send_request(ACT_SEQ, tmpl_base[0], 6'd0);
    send_request(ACT_SEQ, tmpl_base[1], 6'd63);
    send_request(ACT_SEQ, pick_base(), 6'd0);
  endtask

  task automatic test_length_clamp();
    set_scoring(3, -1, -1, 4, 0);
    send_request(ACT_SEQ, tmpl_base[0], 6'd0);
    send_request(ACT_SEQ, pick_base(), 6'd0);
    set_scoring(3, -1, -1, 4, 127);
    send_request(ACT_SEQ, tmpl_base[5], 6'd0);
    set_scoring(3, -1, -1, 4, 3);
    send_request(ACT_SEQ, tmpl_base[2], 6'd0);
    send_request(ACT_SEQ, tmpl_base[3], 6'd0);
    set_scoring(3, -1, -1, 4, 64);
    send_request(ACT_SEQ, tmpl_base[4], 6'd0);
  endtask

  task automatic test_coefficient_extremes();
    set_scoring(127, -128, -128, 0, 64);
    send_request(ACT_SEQ, tmpl_base[0], 6'd0);
    send_request(ACT_SEQ, tmpl_base[1], 6'd0);
    set_scoring(-128, -128, -128, 65535, 8);
    send_request(ACT_SEQ, tmpl_base[0], 6'd0);
    set_scoring(0, 0, 0, 0, 8);
    send_request(ACT_SEQ, tmpl_base[0], 6'd0);
  endtask

  task automatic test_restart_and_ignored();
    set_scoring(5, -3, -2, 12, 64);
    cfg_write(REG_SPARE, 16'($urandom));
    send_request(ACT_RESTART, 8'hff, 6'd63);
    send_request(ACT_NONE, 8'hff, 6'd63);
    send_request(ACT_NONE, 8'h00, 6'd0);
    send_request(ACT_LOAD, 8'h00, 6'd0);
    send_request(ACT_LOAD, 8'hff, 6'd63);
    send_request(ACT_SEQ, 8'h00, 6'd0);
    send_request(ACT_SEQ, 8'hff, 6'd63);
    send_request(ACT_RESTART, 8'h00, 6'd0);
    send_request(ACT_SEQ, 8'hff, 6'd0);
  endtask

  // every move adds the maximum, so the last rows pass the score ceiling after
  // a few hundred columns
  task automatic test_score_saturation();
    set_scoring(127, 127, 127, 65535, 64);
    send_request(ACT_RESTART, 8'h00, 6'd0);
    for (int i = 0; i < 470; i++) send_request(ACT_SEQ, pick_base(), 6'($urandom));
    send_request(ACT_RESTART, 8'h00, 6'd0);
  endtask

  task automatic test_random_phase(int n);
    int done, roll, len;
    done = 0;
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
    if ($urandom_range(0, 3) == 0)
      set_scoring($signed(8'($urandom)), $signed(8'($urandom)), $signed(8'($urandom)),
                  $urandom_range(0, 65535), len);
    else
      set_scoring($urandom_range(1, 20), -$urandom_range(0, 20), -$urandom_range(0, 12),
                  $urandom_range(0, 60), len);
    while (done < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_request(ACT_SEQ, pick_base(), 6'($urandom));
        done++;
      end else if (roll < 78) begin
        send_request(ACT_RESTART, 8'($urandom), 6'($urandom));
        done++;
      end else if (roll < 92) begin
        send_request(ACT_LOAD, pick_base(), 6'($urandom));
        done++;
      end else begin
        send_request(ACT_NONE, 8'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_index_i         = '0;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    in_action_i         = ACT_LOAD;
    in_base_i           = '0;
    in_template_index_i = '0;
    foreach (col_scores[i]) col_scores[i] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_defaults();
    test_length_clamp();
    test_coefficient_extremes();
    test_restart_and_ignored();
    test_score_saturation();
    for (int p = 0; p < 3; p++) test_random_phase(32);
    quiet = 1'b1;
    test_random_phase(32);

    wait_drained();
    if (errors == 0) begin
      $display("local_alignment_score_fill_test: done, clean");
    end else begin
      $display("local_alignment_score_fill_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("local_alignment_score_fill_test: done, errors");
    $finish;
  end

endmodule
